@@ rtl/core/huffman_header_varint_parser_macros.svh @@
// Assertion helpers for the header parser checker.
`ifndef HUFFMAN_HEADER_VARINT_PARSER_MACROS_SVH
`define HUFFMAN_HEADER_VARINT_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HVP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/hvp_pkg.sv @@
package hvp_pkg;

    // Width of the saturating payload byte counter.
    localparam int PAYLOAD_COUNT_WIDTH = 32;

    // Result queue depth: two pushes per transfer at most.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Result kinds.
    localparam logic [2:0] K_COUNT    = 3'd0;
    localparam logic [2:0] K_ENTRY    = 3'd1;
    localparam logic [2:0] K_TRAILER  = 3'd2;
    localparam logic [2:0] K_SMALL    = 3'd3;
    localparam logic [2:0] K_EOF_SYM  = 3'd4;
    localparam logic [2:0] K_EOF_VAR  = 3'd5;
    localparam logic [2:0] K_OVERFLOW = 3'd6;
    localparam logic [2:0] K_NO_LAST  = 3'd7;

    localparam int VARINT_MAX_BYTES = 10;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] entry_index;
        logic [7:0]  symbol_value;
        logic [63:0] frequency;
        logic [3:0]  varint_length;
        logic [15:0] entry_total;
        logic [7:0]  final_bits;
        logic [31:0] payload_bytes;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic push0;
        logic push1;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic room2;
        logic valid;
    } t_fifo_sts;

endpackage

@@ rtl/core/hvp_byte_if.sv @@
interface hvp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

@@ rtl/core/hvp_result_if.sv @@
interface hvp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] entry_index;
    logic [7:0]  symbol_value;
    logic [63:0] frequency;
    logic [3:0]  varint_length;
    logic [15:0] entry_total;
    logic [7:0]  final_bits;
    logic [31:0] payload_bytes;
    logic        last_of_run;

    modport source (
        output valid, output kind, output entry_index, output symbol_value,
        output frequency, output varint_length, output entry_total,
        output final_bits, output payload_bytes, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input kind, input entry_index, input symbol_value,
        input frequency, input varint_length, input entry_total,
        input final_bits, input payload_bytes, input last_of_run,
        output ready
    );
endinterface

@@ rtl/core/hvp_res_fifo.sv @@
module hvp_res_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hvp_pkg::t_fifo_ctl i_ctl,
    input  hvp_pkg::t_result   i_data0,
    input  hvp_pkg::t_result   i_data1,
    output hvp_pkg::t_fifo_sts o_sts,
    output hvp_pkg::t_result   o_data
);

    hvp_pkg::t_result r_mem [hvp_pkg::RES_DEPTH];

    logic [hvp_pkg::RES_PTR_W-1:0] r_wr;
    logic [hvp_pkg::RES_PTR_W-1:0] r_rd;
    logic [hvp_pkg::RES_CNT_W-1:0] r_cnt;
    logic [hvp_pkg::RES_CNT_W-1:0] n_cnt;
    logic [hvp_pkg::RES_PTR_W-1:0] w_wr1;
    logic [1:0]                    w_pushes;

    assign w_wr1    = r_wr + hvp_pkg::RES_PTR_W'(1);
    assign w_pushes = {1'b0, i_ctl.push0} + {1'b0, i_ctl.push1};
    assign n_cnt    = r_cnt + hvp_pkg::RES_CNT_W'(w_pushes)
                      - hvp_pkg::RES_CNT_W'(i_ctl.pop);

    always_ff @(posedge i_clk) begin
        if (i_ctl.push0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_ctl.push1) begin
            r_mem[w_wr1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + hvp_pkg::RES_PTR_W'(w_pushes);
            r_rd  <= r_rd + hvp_pkg::RES_PTR_W'(i_ctl.pop);
            r_cnt <= n_cnt;
        end
    end

    // Leave room for the two results one byte can raise.
    assign o_sts.room2 = (r_cnt <= hvp_pkg::RES_CNT_W'(hvp_pkg::RES_DEPTH - 2));
    assign o_sts.valid = (r_cnt != '0);
    assign o_data      = r_mem[r_rd];

endmodule

@@ rtl/core/huffman_header_varint_parser.sv @@
// Header parser for a Huffman-coded buffer, fed one byte per transfer.
// Input channel i_in carries data_byte and end_of_buffer; the byte flagged
// end_of_buffer closes the buffer and the next byte opens a new one.
// Output channel o_out carries one result per transfer: count, entry
// (symbol plus LEB128 frequency), trailer, or one of five error kinds.
// One input byte raises zero, one or two results; last_of_run marks the
// final result of a byte.
// Throughput: one byte per cycle while the queue has room. The parse runs
// in the cycle of the transfer, between the state registers and a four-deep
// result queue. A result shows on o_out the cycle after its byte is taken
// if the queue was empty. i_in.ready is high while the queue holds two or
// fewer results, which keeps room for the two results one byte can raise; a
// stalled receiver halts the input once three results wait; none is dropped.
// Reset (synchronous, active low) empties the queue and returns the parser
// to the count-low phase with all counters cleared.
module huffman_header_varint_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hvp_byte_if.sink          i_in,
    hvp_result_if.source      o_out
);

    // Parser phases.
    localparam logic [2:0] PH_CNT_LO   = 3'd0;
    localparam logic [2:0] PH_CNT_HI   = 3'd1;
    localparam logic [2:0] PH_SYMBOL   = 3'd2;
    localparam logic [2:0] PH_VARINT   = 3'd3;
    localparam logic [2:0] PH_LASTBITS = 3'd4;
    localparam logic [2:0] PH_PAYLOAD  = 3'd5;
    localparam logic [2:0] PH_DRAIN    = 3'd6;

    localparam int PCW = hvp_pkg::PAYLOAD_COUNT_WIDTH;

    // Parser state.
    logic [2:0]     r_phase,    n_phase;
    logic [7:0]     r_count_lo, n_count_lo;
    logic [15:0]    r_expected, n_expected;
    logic [15:0]    r_done,     n_done;
    logic [7:0]     r_symbol,   n_symbol;
    logic [63:0]    r_freq,     n_freq;
    logic [6:0]     r_shift,    n_shift;
    logic [3:0]     r_vbytes,   n_vbytes;
    logic [7:0]     r_trailer,  n_trailer;
    logic [PCW-1:0] r_pay_cnt,  n_pay_cnt;

    logic               w_accept;
    logic [7:0]         w_byte;
    logic               w_end;
    logic [63:0]        w_freq_or;
    logic [6:0]         w_shift_inc;
    logic [3:0]         w_vbytes_inc;
    logic [15:0]        w_done_inc;
    logic [15:0]        w_count;
    logic [PCW-1:0]     w_pay_next;
    logic [63:0]        w_pay_wide;
    logic [31:0]        w_pay_report;

    hvp_pkg::t_result   w_res_a;
    hvp_pkg::t_result   w_res_b;
    logic               w_a_v;
    logic               w_b_v;
    hvp_pkg::t_result   w_wr0;
    hvp_pkg::t_fifo_ctl w_ctl;
    hvp_pkg::t_fifo_sts w_sts;
    hvp_pkg::t_result   w_head;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_byte   = i_in.data_byte;
    assign w_end    = i_in.end_of_buffer;

    // Merge the next seven data bits in; shifts past bit 63 drop out.
    assign w_freq_or    = r_freq | (r_shift[6] ? 64'd0
                                               : (64'(w_byte[6:0]) << r_shift[5:0]));
    assign w_shift_inc  = r_shift + 7'd7;
    assign w_vbytes_inc = r_vbytes + 4'd1;
    assign w_done_inc   = r_done + 16'd1;
    assign w_count      = {w_byte, r_count_lo};

    // Advance the payload count; hold at all ones.
    assign w_pay_next   = (r_pay_cnt != '1) ? (r_pay_cnt + PCW'(1)) : r_pay_cnt;

    // Report the payload count clipped to 32 bits. A trailer raised on the
    // last-bits byte itself reports zero.
    assign w_pay_wide   = (r_phase == PH_PAYLOAD) ? 64'(w_pay_next) : 64'd0;
    assign w_pay_report = (w_pay_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w_pay_wide[31:0];

    always_comb begin
        n_phase    = r_phase;
        n_count_lo = r_count_lo;
        n_expected = r_expected;
        n_done     = r_done;
        n_symbol   = r_symbol;
        n_freq     = r_freq;
        n_shift    = r_shift;
        n_vbytes   = r_vbytes;
        n_trailer  = r_trailer;
        n_pay_cnt  = r_pay_cnt;
        w_a_v      = 1'b0;
        w_b_v      = 1'b0;
        w_res_a    = '0;
        w_res_b    = '0;

        case (r_phase)
            PH_CNT_LO: begin
                n_count_lo = w_byte;
                n_done     = '0;
                n_expected = '0;
                if (w_end) begin
                    w_a_v        = 1'b1;
                    w_res_a.kind = hvp_pkg::K_SMALL;
                end else begin
                    n_phase = PH_CNT_HI;
                end
            end
            PH_CNT_HI: begin
                n_expected   = w_count;
                n_done       = '0;
                w_a_v        = 1'b1;
                w_res_a.kind = hvp_pkg::K_COUNT;
                n_phase      = (w_count == 16'd0) ? PH_LASTBITS : PH_SYMBOL;
            end
            PH_SYMBOL: begin
                n_symbol = w_byte;
                n_freq   = '0;
                n_shift  = '0;
                n_vbytes = '0;
                n_phase  = PH_VARINT;
                // A symbol closing the buffer counts as an end inside the varint.
                if (w_end) begin
                    w_a_v               = 1'b1;
                    w_res_a.kind        = hvp_pkg::K_EOF_VAR;
                    w_res_a.entry_index = r_done;
                end
            end
            PH_VARINT: begin
                n_freq   = w_freq_or;
                n_shift  = w_shift_inc;
                n_vbytes = w_vbytes_inc;
                if (w_byte[7]) begin
                    if (w_shift_inc > 7'd63) begin
                        w_a_v               = 1'b1;
                        w_res_a.kind        = hvp_pkg::K_OVERFLOW;
                        w_res_a.entry_index = r_done;
                        n_phase             = PH_DRAIN;
                    end else if (w_end) begin
                        w_a_v               = 1'b1;
                        w_res_a.kind        = hvp_pkg::K_EOF_VAR;
                        w_res_a.entry_index = r_done;
                    end
                end else begin
                    w_a_v                 = 1'b1;
                    w_res_a.kind          = hvp_pkg::K_ENTRY;
                    w_res_a.entry_index   = r_done;
                    w_res_a.symbol_value  = r_symbol;
                    w_res_a.frequency     = w_freq_or;
                    w_res_a.varint_length = w_vbytes_inc;
                    n_done                = w_done_inc;
                    n_phase = (w_done_inc == r_expected) ? PH_LASTBITS : PH_SYMBOL;
                end
            end
            PH_LASTBITS: begin
                n_trailer = w_byte;
                n_pay_cnt = '0;
                n_phase   = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_pay_cnt = w_pay_next;
            end
            default: begin
                // Drain after an overflow: drop bytes until the buffer ends.
            end
        endcase

        // The final byte closes the buffer, possibly with a second result.
        if (w_end) begin
            case (n_phase)
                PH_SYMBOL: begin
                    w_b_v               = 1'b1;
                    w_res_b.kind        = hvp_pkg::K_EOF_SYM;
                    w_res_b.entry_index = n_done;
                end
                PH_LASTBITS: begin
                    w_b_v               = 1'b1;
                    w_res_b.kind        = hvp_pkg::K_NO_LAST;
                    w_res_b.entry_index = n_done;
                end
                PH_PAYLOAD: begin
                    w_b_v                 = 1'b1;
                    w_res_b.kind          = hvp_pkg::K_TRAILER;
                    w_res_b.final_bits    = n_trailer;
                    w_res_b.payload_bytes = w_pay_report;
                end
                default: begin
                end
            endcase
            n_phase = PH_CNT_LO;
        end

        w_res_a.entry_total = n_expected;
        w_res_b.entry_total = n_expected;
        w_res_a.last_of_run = !w_b_v;
        w_res_b.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CNT_LO;
            r_count_lo <= '0;
            r_expected <= '0;
            r_done     <= '0;
            r_symbol   <= '0;
            r_freq     <= '0;
            r_shift    <= '0;
            r_vbytes   <= '0;
            r_trailer  <= '0;
            r_pay_cnt  <= '0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_count_lo <= n_count_lo;
            r_expected <= n_expected;
            r_done     <= n_done;
            r_symbol   <= n_symbol;
            r_freq     <= n_freq;
            r_shift    <= n_shift;
            r_vbytes   <= n_vbytes;
            r_trailer  <= n_trailer;
            r_pay_cnt  <= n_pay_cnt;
        end
    end

    // Pack the results of one byte into consecutive queue slots.
    assign w_wr0       = w_a_v ? w_res_a : w_res_b;
    assign w_ctl.push0 = w_accept && (w_a_v || w_b_v);
    assign w_ctl.push1 = w_accept && w_a_v && w_b_v;
    assign w_ctl.pop   = o_out.valid && o_out.ready;

    hvp_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_data0 (w_wr0),
        .i_data1 (w_res_b),
        .o_sts   (w_sts),
        .o_data  (w_head)
    );

    assign i_in.ready          = w_sts.room2;
    assign o_out.valid         = w_sts.valid;
    assign o_out.kind          = w_head.kind;
    assign o_out.entry_index   = w_head.entry_index;
    assign o_out.symbol_value  = w_head.symbol_value;
    assign o_out.frequency     = w_head.frequency;
    assign o_out.varint_length = w_head.varint_length;
    assign o_out.entry_total   = w_head.entry_total;
    assign o_out.final_bits    = w_head.final_bits;
    assign o_out.payload_bytes = w_head.payload_bytes;
    assign o_out.last_of_run   = w_head.last_of_run;

endmodule

@@ rtl/core/hvp_checker.sv @@
`include "huffman_header_varint_parser_macros.svh"

module hvp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic [63:0] i_frequency,
    input logic [3:0]  i_varint_length,
    input logic [15:0] i_entry_total,
    input logic        i_last_of_run
);

    `HVP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result withdrawn while stalled")

    `HVP_ASSERT_SAME(a_entry_len, i_clk, i_rst_n, i_out_valid && (i_kind == hvp_pkg::K_ENTRY), (i_varint_length != 4'd0) && (i_varint_length <= 4'(hvp_pkg::VARINT_MAX_BYTES)), "entry varint length out of range")

    `HVP_ASSERT_SAME(a_nonentry_zero, i_clk, i_rst_n, i_out_valid && (i_kind != hvp_pkg::K_ENTRY), (i_frequency == 64'd0) && (i_varint_length == 4'd0), "frequency set on a non-entry result")

    `HVP_ASSERT_SAME(a_small_alone, i_clk, i_rst_n, i_out_valid && (i_kind == hvp_pkg::K_SMALL), i_last_of_run && (i_entry_total == 16'd0), "too-small result not alone or with a count")

endmodule

bind huffman_header_varint_parser hvp_checker u_hvp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_kind          (o_out.kind),
    .i_frequency     (o_out.frequency),
    .i_varint_length (o_out.varint_length),
    .i_entry_total   (o_out.entry_total),
    .i_last_of_run   (o_out.last_of_run)
);
